// ===== src/ftd_pkg.sv =====
package ftd_pkg;

   // field widths of the two channels
   localparam int FloatW  = 32;
   localparam int CapW    = 8;
   localparam int CharW   = 8;
   localparam int StatusW = 2;
   localparam int LenW    = 5;

   // formatting
   localparam int FracDigitsDefault = 6;
   localparam int MaxText           = 16;
   localparam int IntDigits         = 8;   // 2^24 - 1 needs eight decimal digits

   // single-precision layout
   localparam int             MantBits = 23;
   localparam logic [7:0]     ExpBias  = 8'd127;
   localparam logic [7:0]     ExpMax   = 8'd255;
   localparam logic [7:0]     ExpLimit = 8'd151;   // bias + 24: magnitude 2^24 and up

   // status codes
   localparam logic [StatusW-1:0] StatusOk    = 2'd0;
   localparam logic [StatusW-1:0] StatusCap   = 2'd1;
   localparam logic [StatusW-1:0] StatusRange = 2'd2;

   // ASCII codes
   localparam logic [CharW-1:0] CharNone  = 8'h00;
   localparam logic [CharW-1:0] CharMinus = 8'h2D;
   localparam logic [CharW-1:0] CharDot   = 8'h2E;
   localparam logic [CharW-1:0] CharZero  = 8'h30;

   // control of the binary to BCD shifter
   typedef struct packed {
      logic clear;
      logic shift;
      logic bit_in;
   } dabble_ctl_type;

endpackage

// ===== src/ftd_if.sv =====
// input channel: one float word and a text capacity per item
interface ftd_req_if;
   import ftd_pkg::*;
   logic                valid;
   logic                ready;
   logic [FloatW-1:0]   float_bits;
   logic [CapW-1:0]     capacity;

   modport source (output valid, float_bits, capacity, input ready);
   modport sink   (input valid, float_bits, capacity, output ready);
endinterface

// result channel: one character per item
interface ftd_rsp_if;
   import ftd_pkg::*;
   logic                valid;
   logic                ready;
   logic [CharW-1:0]    character;
   logic                last_char;
   logic [StatusW-1:0]  status;
   logic [LenW-1:0]     text_length;

   modport source (output valid, character, last_char, status, text_length, input ready);
   modport sink   (input valid, character, last_char, status, text_length, output ready);
endinterface

// ===== src/float32_to_decimal_text.sv =====
// Single-precision float to fixed-point decimal text.
// req_ch (valid/ready) takes one item: float_bits and capacity, the room for the
// text plus a terminator. rsp_ch gives the text one character per item: an
// optional '-', the integer digits, '.', and the truncated fraction digits;
// last_char marks the final character and text_length repeats the length on
// every character. Out-of-range values (magnitude 2^24 and up, infinity, NaN)
// and a too small capacity give one item with character 0, text_length 0,
// last_char 1 and the status code.
// Timing: one item is in work at a time. After acceptance the integer bits are
// shifted through a BCD shifter one bit per cycle (up to 24 shifts, or up to
// 4*FRACTION_DIGITS right shifts for values below one half), then one fraction
// digit per cycle by a times-ten step, a length check step, then one character
// per cycle (up to 16) while the receiver takes them. A stalled receiver holds
// the output register and the character sequence; a new item is taken while the
// last character still waits.
// Reset (synchronous) empties the output register and returns to idle.
module float32_to_decimal_text #(
   parameter int FRACTION_DIGITS = ftd_pkg::FracDigitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   ftd_req_if.sink     req_ch,
   ftd_rsp_if.source   rsp_ch
);
   import ftd_pkg::*;

   localparam int FracExt = 4 * FRACTION_DIGITS;
   localparam int FracW   = MantBits + 1 + FracExt;
   localparam int CntMax  = (FracExt > MantBits + 1) ? FracExt : MantBits + 1;
   localparam int CntW    = $clog2(CntMax + 1);
   localparam int FdIdxW  = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
   localparam int NdW     = $clog2(IntDigits + 1);
   localparam int IdxW    = $clog2(IntDigits);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StAlign = 3'd1;
   localparam logic [2:0] StFrac  = 3'd2;
   localparam logic [2:0] StCheck = 3'd3;
   localparam logic [2:0] StEmit  = 3'd4;
   localparam logic [2:0] StErr   = 3'd5;

   // control state
   logic [2:0]        state_ff, state_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [LenW-1:0]   pos_ff, pos_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // working data
   logic [FracW-1:0]  f_ff, f_in;
   logic              left_ff, left_in;
   logic              neg_ff, neg_in;
   logic [CapW-1:0]   cap_ff, cap_in;
   logic [StatusW-1:0] err_ff, err_in;
   logic [NdW-1:0]    nd_ff, nd_in;
   logic [LenW-1:0]   len_ff, len_in;
   logic [3:0]        frac_dig_ff [FRACTION_DIGITS];
   logic [3:0]        frac_dig_in [FRACTION_DIGITS];

   // output register
   logic [CharW-1:0]   char_ff, char_in;
   logic               last_ff, last_in;
   logic [StatusW-1:0] status_ff, status_in;
   logic [LenW-1:0]    tlen_ff, tlen_in;

   // input decode
   logic              sign;
   logic [7:0]        expf;
   logic [MantBits-1:0] man;
   logic              is_zero;
   logic              out_range;
   logic [7:0]        left_cnt;
   logic [7:0]        right_cnt;
   logic              accept;
   logic              out_free;

   assign sign      = req_ch.float_bits[FloatW-1];
   assign expf      = req_ch.float_bits[FloatW-2:MantBits];
   assign man       = req_ch.float_bits[MantBits-1:0];
   assign is_zero   = (expf == 8'd0) && (man == '0);
   assign out_range = !is_zero && ((expf == ExpMax) || (expf >= ExpLimit));
   assign left_cnt  = expf - (ExpBias - 8'd1);
   assign right_cnt = (ExpBias - 8'd1) - expf;

   assign req_ch.ready = (state_ff == StIdle);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // integer part converter
   dabble_ctl_type          dab_ctl;
   logic [IntDigits*4-1:0]  bcd;

   assign dab_ctl.clear  = accept;
   assign dab_ctl.shift  = (state_ff == StAlign) && left_ff;
   assign dab_ctl.bit_in = f_ff[FracW-1];

   ftd_dabble #(.DIGITS(IntDigits)) u_dabble (
      .clock (clock),
      .ctl   (dab_ctl),
      .bcd   (bcd)
   );

   // times-ten step on the fraction: the carry out is the next digit
   logic [FracW+3:0] prod;
   assign prod = {1'b0, f_ff, 3'b000} + {3'b000, f_ff, 1'b0};

   // integer digit count, at least one
   logic [NdW-1:0] nd_calc;
   always_comb begin
      nd_calc = NdW'(1);
      for (int i = 1; i < IntDigits; i++) begin
         if (bcd[i*4 +: 4] != 4'd0) begin
            nd_calc = NdW'(i + 1);
         end
      end
   end

   // text length and capacity check
   logic [LenW-1:0] len_calc;
   logic            cap_err;
   assign len_calc = LenW'(neg_ff) + LenW'(nd_calc) + LenW'(FRACTION_DIGITS + 1);
   assign cap_err  = (len_calc > LenW'(MaxText)) || (cap_ff <= CapW'(len_calc));

   // character at the current position
   logic [LenW-1:0]   p;
   logic [LenW-1:0]   int_off;
   logic [LenW-1:0]   frac_off;
   logic [IdxW-1:0]   int_idx;
   logic [FdIdxW-1:0] frac_idx;
   logic [CharW-1:0]  emit_char;

   assign p        = pos_ff - LenW'(neg_ff);
   assign int_off  = LenW'(nd_ff) - LenW'(1) - p;
   assign frac_off = p - LenW'(nd_ff) - LenW'(1);
   assign int_idx  = int_off[IdxW-1:0];
   assign frac_idx = frac_off[FdIdxW-1:0];

   always_comb begin
      if (neg_ff && (pos_ff == '0)) begin
         emit_char = CharMinus;
      end else if (p < LenW'(nd_ff)) begin
         emit_char = CharZero | {4'b0000, bcd[int_idx*4 +: 4]};
      end else if (p == LenW'(nd_ff)) begin
         emit_char = CharDot;
      end else begin
         emit_char = CharZero | {4'b0000, frac_dig_ff[frac_idx]};
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      f_in         = f_ff;
      left_in      = left_ff;
      neg_in       = neg_ff;
      cap_in       = cap_ff;
      err_in       = err_ff;
      nd_in        = nd_ff;
      len_in       = len_ff;
      frac_dig_in  = frac_dig_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      tlen_in      = tlen_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               cap_in  = req_ch.capacity;
               neg_in  = sign && !is_zero;
               left_in = 1'b0;
               f_in    = {1'b1, man, {FracExt{1'b0}}};
               cnt_in  = CntW'(FRACTION_DIGITS);
               if (out_range) begin
                  err_in   = StatusRange;
                  state_in = StErr;
               end else if (is_zero) begin
                  f_in     = '0;
                  state_in = StFrac;
               end else if (expf >= ExpBias) begin
                  left_in  = 1'b1;
                  cnt_in   = left_cnt[CntW-1:0];
                  state_in = StAlign;
               end else if (expf == ExpBias - 8'd1) begin
                  state_in = StFrac;
               end else if (right_cnt > 8'(FracExt)) begin
                  // too small to reach any fraction digit
                  f_in     = '0;
                  state_in = StFrac;
               end else begin
                  cnt_in   = right_cnt[CntW-1:0];
                  state_in = StAlign;
               end
            end
         end
         StAlign: begin
            if (left_ff) begin
               f_in = {f_ff[FracW-2:0], 1'b0};
            end else begin
               f_in = {1'b0, f_ff[FracW-1:1]};
            end
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) begin
               cnt_in   = CntW'(FRACTION_DIGITS);
               state_in = StFrac;
            end
         end
         StFrac: begin
            f_in = prod[FracW-1:0];
            for (int i = 0; i < FRACTION_DIGITS - 1; i++) begin
               frac_dig_in[i] = frac_dig_ff[i+1];
            end
            frac_dig_in[FRACTION_DIGITS-1] = prod[FracW+3:FracW];
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) begin
               state_in = StCheck;
            end
         end
         StCheck: begin
            nd_in  = nd_calc;
            len_in = len_calc;
            pos_in = '0;
            if (cap_err) begin
               err_in   = StatusCap;
               state_in = StErr;
            end else begin
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = emit_char;
               last_in      = (pos_ff == len_ff - LenW'(1));
               status_in    = StatusOk;
               tlen_in      = len_ff;
               pos_in       = pos_ff + LenW'(1);
               if (pos_ff == len_ff - LenW'(1)) begin
                  state_in = StIdle;
               end
            end
         end
         StErr: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CharNone;
               last_in      = 1'b1;
               status_in    = err_ff;
               tlen_in      = '0;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      f_ff        <= f_in;
      left_ff     <= left_in;
      neg_ff      <= neg_in;
      cap_ff      <= cap_in;
      err_ff      <= err_in;
      nd_ff       <= nd_in;
      len_ff      <= len_in;
      frac_dig_ff <= frac_dig_in;
      char_ff     <= char_in;
      last_ff     <= last_in;
      status_ff   <= status_in;
      tlen_ff     <= tlen_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.character   = char_ff;
   assign rsp_ch.last_char   = last_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.text_length = tlen_ff;

endmodule

// ===== src/ftd_dabble.sv =====
// Shift-and-add-3 binary to BCD converter, one input bit per shift, MSB first.
module ftd_dabble #(
   parameter int DIGITS = ftd_pkg::IntDigits
) (
   input  logic                         clock,
   input  ftd_pkg::dabble_ctl_type      ctl,
   output logic [DIGITS*4-1:0]          bcd
);
   import ftd_pkg::*;

   logic [DIGITS*4-1:0] bcd_ff;
   logic [DIGITS*4-1:0] bcd_in;
   logic [DIGITS*4-1:0] adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      bcd_in = bcd_ff;
      if (ctl.clear) begin
         bcd_in = '0;
      end else if (ctl.shift) begin
         bcd_in = {adj[DIGITS*4-2:0], ctl.bit_in};
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
   end

   assign bcd = bcd_ff;

endmodule
